[hw/rtl/lkvc_pkg.sv]
// shared types, constants and helpers for the lru key/value cache
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FETCH,
        ST_COMMIT
    } state_t;

    // compare stage control toward the scan unit
    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    // the entry under compare
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
    } scan_entry_t;

    // what the scan found
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              victim_found;
        logic [IDX_W-1:0]  victim_idx;
    } scan_res_t;

    // write port of the key/value store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } store_wr_t;

    // capacity zero acts as one, above the entry count it saturates
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0)
        begin
            res = CNT_W'(1);
        end
        else if (int'(cap) > ENTRIES)
        begin
            res = CNT_W'(ENTRIES);
        end
        else
        begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage

[hw/rtl/lru_key_value_cache_top.sv]
// top level of the lru key/value cache: sequencer, recency ranks, result register
// an accepted beat passes scan, last compare, fetch (held until the result register is free)
//   and commit; no new beat is taken before that; the key search compares one entry per cycle
//   through a single comparator fed by the key memory read port, so the scan scales with ENTRIES
// s_tready is high only while the sequencer idles; a waiting result beat does not block it
// reset: valid bits, ranks, occupancy and control clear at once; capacity returns to 16;
//   the key and value memories are left as they are and need no clearing pass
module lru_key_value_cache_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // key [31:0], write_value [63:32]
    input  logic [0:0]                    s_tuser,   // operation [0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // read_value [31:0], evicted_key [63:32]
    output logic [1:0]                    m_tuser,   // found [0], evicted [1]
    // capacity register
    input  logic                          cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata
);

    localparam int ENTRIES = lkvc_pkg::ENTRIES;
    localparam int IDX_W   = lkvc_pkg::IDX_W;
    localparam int RANK_W  = lkvc_pkg::RANK_W;
    localparam int CNT_W   = lkvc_pkg::CNT_W;
    localparam int KEY_W   = lkvc_pkg::KEY_W;
    localparam int VAL_W   = lkvc_pkg::VAL_W;

    // sequencer
    lkvc_pkg::state_t state_reg;
    lkvc_pkg::state_t state_next;

    // latched input beat
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] wval_reg;

    // scan address and compare stage
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // per-entry status, kept in flops so reset clears it at once
    logic              valid_reg [ENTRIES];
    logic              valid_next[ENTRIES];
    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [RANK_W-1:0] rank_next [ENTRIES];
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [ENTRIES-1:0] valid_vec;

    // result register
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    // unit hookup
    lkvc_pkg::scan_ctl_t   scan_ctl;
    lkvc_pkg::scan_entry_t scan_entry;
    lkvc_pkg::scan_res_t   scan_res;
    lkvc_pkg::store_wr_t   store_wr;
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_W-1:0]      rd_key;
    logic [VAL_W-1:0]      rd_value;

    // commit datapath
    logic              accept;
    logic              out_free;
    logic              do_commit;
    logic              is_set;
    logic              need_evict;
    logic              do_evict;
    logic              ins_ok;
    logic [IDX_W-1:0]  ins_slot;
    logic              res_found;
    logic [VAL_W-1:0]  res_value;
    logic [KEY_W-1:0]  res_evk;
    logic [RANK_W-1:0] last_rank;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign do_commit = (state_reg == lkvc_pkg::ST_COMMIT);
    assign last_rank = RANK_W'(occ_reg - CNT_W'(1));

    // ---------------------------------------------------------------
    // sequencer: idle, scan all entries, drain last compare, fetch, commit
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        scan_idx_next = scan_idx_reg;
        rd_addr       = scan_idx_reg;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                s_tready      = 1'b1;
                scan_idx_next = '0;
                if (s_tvalid)
                begin
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = lkvc_pkg::ST_LAST;
                end
            end
            lkvc_pkg::ST_LAST:
            begin
                state_next = lkvc_pkg::ST_FETCH;
            end
            lkvc_pkg::ST_FETCH:
            begin
                // hit value for a get, victim key for an eviction
                rd_addr = scan_res.hit ? scan_res.hit_idx : scan_res.victim_idx;
                if (out_free)
                begin
                    state_next = lkvc_pkg::ST_COMMIT;
                end
            end
            lkvc_pkg::ST_COMMIT:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // input latch and scan pointers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser[0];
            key_reg  <= s_tdata[KEY_W-1:0];
            wval_reg <= s_tdata[63:KEY_W];
        end
        cmp_idx_reg <= scan_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= (state_reg == lkvc_pkg::ST_SCAN);
        end
    end

    // ---------------------------------------------------------------
    // shared compare unit and memories
    // ---------------------------------------------------------------
    always_comb
    begin
        scan_ctl.clear   = accept;
        scan_ctl.step    = cmp_vld_reg;
        scan_ctl.idx     = cmp_idx_reg;
        scan_entry.valid = valid_reg[cmp_idx_reg];
        scan_entry.key   = rd_key;
        scan_entry.rank  = rank_reg[cmp_idx_reg];
    end

    lkvc_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .entry      (scan_entry),
        .search_key (key_reg),
        .last_rank  (last_rank),
        .res        (scan_res)
    );

    lkvc_store u_store (
        .clk      (clk),
        .wr       (store_wr),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // ---------------------------------------------------------------
    // commit: result, store write, rank and valid update
    // ---------------------------------------------------------------
    always_comb
    begin
        is_set     = (op_reg == lkvc_pkg::OP_SET);
        need_evict = (occ_reg >= lkvc_pkg::eff_cap(cap_reg));
        do_evict   = is_set && !scan_res.hit && need_evict && scan_res.victim_found;
        ins_ok     = is_set && !scan_res.hit && (do_evict || scan_res.free_found);
        // lowest free slot once the victim is gone
        if (do_evict && !(scan_res.free_found && scan_res.free_idx < scan_res.victim_idx))
        begin
            ins_slot = scan_res.victim_idx;
        end
        else
        begin
            ins_slot = scan_res.free_idx;
        end

        res_found = scan_res.hit;
        if (is_set)
        begin
            res_value = '0;
        end
        else if (scan_res.hit)
        begin
            res_value = rd_value;
        end
        else
        begin
            res_value = lkvc_pkg::MISS_VALUE;
        end
        res_evk = do_evict ? rd_key : '0;

        store_wr.en    = do_commit && is_set && (scan_res.hit || ins_ok);
        store_wr.addr  = scan_res.hit ? scan_res.hit_idx : ins_slot;
        store_wr.key   = key_reg;
        store_wr.value = wval_reg;

        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
        end
        occ_next = occ_reg;

        if (do_commit && scan_res.hit)
        begin
            // refresh: entries newer than the hit age by one
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && IDX_W'(i) != scan_res.hit_idx
                    && rank_reg[i] < scan_res.hit_rank)
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            rank_next[scan_res.hit_idx] = '0;
        end
        else if (do_commit && ins_ok)
        begin
            // insertion: every surviving entry ages by one
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && !(do_evict && IDX_W'(i) == scan_res.victim_idx))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            if (do_evict)
            begin
                valid_next[scan_res.victim_idx] = 1'b0;
            end
            valid_next[ins_slot] = 1'b1;
            rank_next[ins_slot]  = '0;
            occ_next = do_evict ? occ_reg : occ_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
            occ_reg <= '0;
            cap_reg <= lkvc_pkg::CAP_RESET;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
            occ_reg <= occ_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // ---------------------------------------------------------------
    // result register; fetch waits until it is free, so commit always loads
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (do_commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_commit)
        begin
            m_tdata_reg <= {res_evk, res_value};
            m_tuser_reg <= {do_evict, res_found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // valid bits gathered into one vector for counting
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_vec[i] = valid_reg[i];
        end
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= ENTRIES)
        else $error("occupancy above entry count");

    a_evict_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("eviction reported on a hit");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == lkvc_pkg::ST_COMMIT))
        else $error("result beat without a commit");

endmodule

[hw/rtl/lkvc_store.sv]
// key and value memories, one write port and one registered read port
module lkvc_store (
    input  logic                          clk,
    input  lkvc_pkg::store_wr_t           wr,
    input  logic [lkvc_pkg::IDX_W-1:0]    rd_addr,
    output logic [lkvc_pkg::KEY_W-1:0]    rd_key,
    output logic [lkvc_pkg::VAL_W-1:0]    rd_value
);

    logic [lkvc_pkg::KEY_W-1:0] key_mem   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] value_mem [lkvc_pkg::ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr]   <= wr.key;
            value_mem[wr.addr] <= wr.value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

[hw/rtl/lkvc_scan.sv]
// shared compare unit: one entry per step, keeps hit, first free slot and victim
module lkvc_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkvc_pkg::scan_ctl_t           ctl,
    input  lkvc_pkg::scan_entry_t         entry,
    input  logic [lkvc_pkg::KEY_W-1:0]    search_key,
    input  logic [lkvc_pkg::RANK_W-1:0]   last_rank,
    output lkvc_pkg::scan_res_t           res
);

    lkvc_pkg::scan_res_t res_reg;
    lkvc_pkg::scan_res_t res_next;
    logic                key_eq;

    // the one key comparator
    assign key_eq = (entry.key == search_key);

    always_comb
    begin
        res_next = res_reg;
        if (ctl.clear)
        begin
            res_next.hit          = 1'b0;
            res_next.free_found   = 1'b0;
            res_next.victim_found = 1'b0;
        end
        else if (ctl.step)
        begin
            if (entry.valid && key_eq && !res_reg.hit)
            begin
                res_next.hit      = 1'b1;
                res_next.hit_idx  = ctl.idx;
                res_next.hit_rank = entry.rank;
            end
            if (!entry.valid && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = ctl.idx;
            end
            // ranks of valid entries are distinct, the oldest holds occupancy-1
            if (entry.valid && entry.rank == last_rank)
            begin
                res_next.victim_found = 1'b1;
                res_next.victim_idx   = ctl.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[dv/tb_lru_key_value_cache_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the lru key/value cache, directed table then random traffic
module tb_lru_key_value_cache_top;

    localparam int ENTRIES      = lkvc_pkg::ENTRIES;
    localparam int KEY_W        = lkvc_pkg::KEY_W;
    localparam int VAL_W        = lkvc_pkg::VAL_W;
    localparam int CAP_W        = lkvc_pkg::CAP_W;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int LATENCY      = ENTRIES + 4;
    localparam int STALL_LIMIT  = 3000;   // cycles without any beat or register write
    localparam int RX_HOLD      = 400;    // one long result back-pressure stretch
    localparam int RX_HOLD_AT   = 300;    // result beats seen before that stretch starts
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 140;
    localparam int PROBE_ROWS   = 27;
    localparam int POOL_MAX     = 24;
    localparam int EXP_DEPTH    = 8;      // expected results in flight, ring size

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_result_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CAP_W-1:0] cap;
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wval;
        logic             typed;   // 1: use want below, 0: take the predictor's answer
        cache_result_t    want;
    } probe_row_t;

    localparam cache_result_t R_MISS  = '{1'b0, lkvc_pkg::MISS_VALUE, 1'b0, '0};
    localparam cache_result_t R_NEW   = '{1'b0, '0, 1'b0, '0};   // set of a new key, no victim
    localparam cache_result_t R_UPD   = '{1'b1, '0, 1'b0, '0};   // set of a present key
    localparam cache_result_t R_PRED  = '0;

    // directed walk: extremes of key and value, every operation, capacity zero,
    // capacity above the entry count, capacity lowered below occupancy
    localparam probe_row_t PROBE [PROBE_ROWS] = '{
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, R_MISS},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, R_NEW},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
          '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, R_NEW},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, R_NEW},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h8000_0000, 32'h0000_0000, 1'b1, R_UPD},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
          '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, R_MISS},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, R_PRED},
        '{ROW_CFG,  5'd0,  lkvc_pkg::OP_GET, 32'h0,         32'h0,         1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0001, 32'h1111_1111, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0002, 32'h2222_2222, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0002, 32'h3333_3333, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0003, 32'hCCCC_CCCC, 1'b0, R_PRED},
        '{ROW_CFG,  5'd31, lkvc_pkg::OP_GET, 32'h0,         32'h0,         1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0004, 32'h4444_4444, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0005, 32'h5555_5555, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0000, 32'hAAAA_AAAA, 1'b0, R_PRED},
        '{ROW_CFG,  5'd1,  lkvc_pkg::OP_GET, 32'h0,         32'h0,         1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h0000_0006, 32'h6666_6666, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, R_PRED},
        '{ROW_CFG,  5'd16, lkvc_pkg::OP_GET, 32'h0,         32'h0,         1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_SET, 32'h5555_5555, 32'h0F0F_0F0F, 1'b0, R_PRED},
        '{ROW_ITEM, 5'd0,  lkvc_pkg::OP_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, R_PRED}
    };

    // capacity per random phase; index 8 is replaced by a random value
    localparam logic [CAP_W-1:0] PHASE_CAP [PHASES] = '{
        5'd0, 5'd31, 5'd1, 5'd2, 5'd16, 5'd17, 5'd8, 5'd15, 5'd4, 5'd3
    };

    localparam logic [KEY_W-1:0] EXTREME_KEYS [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;   // key [31:0], write_value [63:32]
    logic [0:0]       s_tuser   = '0;   // operation [0]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [63:0]      m_tdata;          // read_value [31:0], evicted_key [63:32]
    logic [1:0]       m_tuser;          // found [0], evicted [1]
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    // shadow copy of the cache contents
    logic [KEY_W-1:0] mdl_key   [ENTRIES];
    logic [VAL_W-1:0] mdl_val   [ENTRIES];
    bit               mdl_valid [ENTRIES];
    int unsigned      mdl_rank  [ENTRIES];
    int unsigned      mdl_occ   = 0;
    logic [CAP_W-1:0] mdl_cap   = lkvc_pkg::CAP_RESET;

    // expected results in accept order: written by the sender, read by the checker
    cache_result_t    exp_ring [EXP_DEPTH];
    int               exp_wr      = 0;
    int               exp_rd      = 0;
    int               fails       = 0;
    int               idle_cycles = 0;
    int               tx_calm     = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lru_key_value_cache_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // one lookup or store against the shadow copy, with lru aging
    function automatic cache_result_t cache_access(input logic op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] wval);
        cache_result_t res;
        int            slot;
        int            victim;
        int unsigned   limit;
        int unsigned   hit_rank;
        res    = '0;
        slot   = -1;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (mdl_valid[i] && mdl_key[i] == key && slot < 0)
                slot = i;
        if (slot >= 0)
        begin
            res.found = 1'b1;
            if (op == lkvc_pkg::OP_GET)
                res.read_value = mdl_val[slot];
            else
                mdl_val[slot] = wval;
            // entries more recent than the hit age by one
            hit_rank = mdl_rank[slot];
            for (int i = 0; i < ENTRIES; i++)
                if (mdl_valid[i] && i != slot && mdl_rank[i] < hit_rank)
                    mdl_rank[i]++;
            mdl_rank[slot] = 0;
        end
        else if (op == lkvc_pkg::OP_GET)
        begin
            res.read_value = lkvc_pkg::MISS_VALUE;
        end
        else
        begin
            // zero acts as one, anything above the entry count saturates
            if (mdl_cap == '0)
                limit = 1;
            else if (int'(mdl_cap) > ENTRIES)
                limit = ENTRIES;
            else
                limit = mdl_cap;
            if (mdl_occ >= limit)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (mdl_valid[i] && (victim < 0 || mdl_rank[i] > mdl_rank[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    res.evicted     = 1'b1;
                    res.evicted_key = mdl_key[victim];
                    mdl_valid[victim] = 1'b0;
                    mdl_occ--;
                end
            end
            for (int i = 0; i < ENTRIES; i++)
                if (!mdl_valid[i] && slot < 0)
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (mdl_valid[i])
                        mdl_rank[i]++;
                mdl_key[slot]   = key;
                mdl_val[slot]   = wval;
                mdl_valid[slot] = 1'b1;
                mdl_rank[slot]  = 0;
                mdl_occ++;
            end
        end
        return res;
    endfunction

    // offer one beat after a random gap, then queue what it must return
    task automatic push_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] wval, input logic typed,
                             input cache_result_t want);
        int            gap;
        int            roll;
        cache_result_t predicted;
        gap = 0;
        if (tx_calm > 0)
        begin
            tx_calm--;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(1, 4);
            else if (roll < 95)
                tx_calm = $urandom_range(20, 50);
            else
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wval, key};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predicted = cache_access(op, key, wval);
        exp_ring[exp_wr % EXP_DEPTH] = typed ? want : predicted;
        exp_wr++;
    endtask

    task automatic wait_all_results();
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    // capacity changes only with nothing in flight
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_cap = cap;
    endtask

    // stimulus
    initial
    begin
        logic [KEY_W-1:0] pool [POOL_MAX];
        int               pool_size;
        int unsigned      span;
        logic [CAP_W-1:0] cap;
        logic             op;
        logic [KEY_W-1:0] key;
        foreach (mdl_valid[i])
        begin
            mdl_valid[i] = 1'b0;
            mdl_rank[i]  = 0;
            mdl_key[i]   = '0;
            mdl_val[i]   = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PROBE[i])
        begin
            if (PROBE[i].kind == ROW_CFG)
                write_capacity(PROBE[i].cap);
            else
                push_item(PROBE[i].op, PROBE[i].key, PROBE[i].wval, PROBE[i].typed,
                          PROBE[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            cap = (ph == 8) ? CAP_W'($urandom_range(0, 31)) : PHASE_CAP[ph];
            write_capacity(cap);
            // key pool a little larger than the capacity gives both hits and evictions
            span = (cap == '0) ? 1 : ((int'(cap) > ENTRIES) ? ENTRIES : cap);
            pool_size = span + $urandom_range(1, 8);
            for (int p = 0; p < pool_size; p++)
                pool[p] = ($urandom_range(0, 5) == 0) ? EXTREME_KEYS[$urandom_range(0, 3)]
                                                      : $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender pauses once mid-phase until the pipe has drained
                if (ph == PHASES / 2 && n == PHASE_ITEMS / 2)
                begin
                    s_tvalid <= 1'b0;
                    wait_all_results();
                end
                op  = ($urandom_range(0, 99) < 55) ? lkvc_pkg::OP_SET : lkvc_pkg::OP_GET;
                key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                                   : $urandom;
                push_item(op, key, $urandom, 1'b0, R_PRED);
            end
        end

        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (LATENCY * 2) @(posedge clk);
        if (fails == 0 && exp_wr == exp_rd)
            $display("lru_key_value_cache_top verification clean");
        else
            $display("lru_key_value_cache_top verification failed");
        $finish;
    end

    // result side back-pressure: calm stretches, short and long stalls,
    // and one long hold so the block fills up and stops taking input
    initial
    begin
        int beats;
        int stall_left;
        int calm_left;
        int roll;
        bit hold_done;
        beats      = 0;
        stall_left = 0;
        calm_left  = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready)
                beats++;
            if (!hold_done && beats >= RX_HOLD_AT)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                m_tready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                begin
                    calm_left = $urandom_range(30, 200);
                    m_tready <= 1'b1;
                end
                else if (roll < 90)
                begin
                    stall_left = $urandom_range(0, 3);
                    m_tready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(20, 60);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // result beat checker
    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("result beat with nothing pending: tdata %h tuser %b", m_tdata, m_tuser);
                fails++;
            end
            else
            begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tuser[0] !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, m_tuser[0]);
                    fails++;
                end
                if (m_tdata[31:0] !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, m_tdata[31:0]);
                    fails++;
                end
                if (m_tuser[1] !== want.evicted)
                begin
                    $error("evicted: expected %0b, got %0b", want.evicted, m_tuser[1]);
                    fails++;
                end
                if (m_tdata[63:32] !== want.evicted_key)
                begin
                    $error("evicted_key: expected %h, got %h", want.evicted_key,
                           m_tdata[63:32]);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any beat or register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("lru_key_value_cache_top verification failed");
            $finish;
        end
    end

endmodule
